// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/plbs_pkg.sv =====
// Package: types and constants of the power line bit-serial master
`timescale 1ns / 1ps
`default_nettype none

package plbs_pkg;

    localparam int DATA_BITS   = 32;
    localparam int WORD_W      = 32;
    localparam int LIMIT_W     = 8;
    localparam int BP_W        = 6;
    localparam int MISS_W      = 9;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam logic [LIMIT_W-1:0] FAULT_LIMIT_RST = 8'd10;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SEND = 2'd1,
        OP_RECV = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEND = 2'd1,
        MODE_RECV = 2'd2
    } mode_t;

    // Control state of the line sequencer
    typedef struct packed {
        logic              phase;
        logic [BP_W-1:0]   bp;
        mode_t             mode;
        logic [MISS_W-1:0] miss;
        logic              line;
    } ctl_t;

    // One result item
    typedef struct packed {
        logic              rejected;
        logic [WORD_W-1:0] received_word;
        logic              recv_timeout;
        logic              recv_done;
        logic              send_done;
        logic              busy_res;
        logic              line_on;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/plbs_step.sv =====
// Next-state and result logic for one item
`timescale 1ns / 1ps
`default_nettype none

module plbs_step #(
    parameter int DATA_BITS = plbs_pkg::DATA_BITS
) (
    input  plbs_pkg::op_t                      op,
    input  logic [plbs_pkg::WORD_W-1:0]        send_word,
    input  logic                               line_sample,
    input  logic [plbs_pkg::LIMIT_W-1:0]       fault_limit,
    input  plbs_pkg::ctl_t                     ctl,
    input  logic [DATA_BITS-1:0]               out_word,
    input  logic [DATA_BITS-1:0]               in_word,
    output plbs_pkg::ctl_t                     ctl_next,
    output logic                               out_word_load,
    output logic [DATA_BITS-1:0]               out_word_next,
    output logic [DATA_BITS-1:0]               in_word_next,
    output plbs_pkg::res_t                     res
);

    localparam int IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
    localparam logic [plbs_pkg::BP_W-1:0] LAST = plbs_pkg::BP_W'(DATA_BITS + 2);

    logic [plbs_pkg::BP_W-1:0]   bp_m2;
    logic [IDX_W-1:0]            idx;
    logic [plbs_pkg::MISS_W-1:0] miss_inc;
    logic                        miss_over;

    assign bp_m2         = ctl.bp - plbs_pkg::BP_W'(2);
    assign idx           = bp_m2[IDX_W-1:0];
    assign out_word_next = send_word[DATA_BITS-1:0];
    // miss counter saturates
    assign miss_inc  = (&ctl.miss) ? ctl.miss : ctl.miss + plbs_pkg::MISS_W'(1);
    assign miss_over = (fault_limit != '0)
                    && (miss_inc > {1'b0, fault_limit});

    always_comb
    begin
        ctl_next      = ctl;
        out_word_load = 1'b0;
        in_word_next  = in_word;
        res           = '0;
        unique case (op) inside
            plbs_pkg::OP_SEND, plbs_pkg::OP_RECV:
            begin
                if (ctl.mode != plbs_pkg::MODE_IDLE)
                begin
                    res.rejected = 1'b1;
                end
                else if (op == plbs_pkg::OP_SEND)
                begin
                    out_word_load = 1'b1;
                    ctl_next.bp   = '0;
                    ctl_next.mode = plbs_pkg::MODE_SEND;
                end
                else
                begin
                    in_word_next  = '0;
                    ctl_next.bp   = '0;
                    ctl_next.mode = plbs_pkg::MODE_RECV;
                end
            end
            plbs_pkg::OP_TICK:
            begin
                ctl_next.phase = ~ctl.phase;
                if (ctl.phase)
                begin
                    if (ctl.mode == plbs_pkg::MODE_SEND)
                    begin
                        ctl_next.bp = ctl.bp + plbs_pkg::BP_W'(1);
                        if (ctl.bp == plbs_pkg::BP_W'(0))
                        begin
                            ctl_next.line = 1'b1;
                        end
                        else if (ctl.bp == plbs_pkg::BP_W'(1))
                        begin
                            ctl_next.line = 1'b0;
                        end
                        else if (ctl.bp < LAST)
                        begin
                            ctl_next.line = out_word[idx];
                        end
                        else if (ctl.bp == LAST)
                        begin
                            // stop bit: drive the line low, then skip bp past LAST
                            ctl_next.line = 1'b0;
                            ctl_next.bp   = ctl.bp + plbs_pkg::BP_W'(2);
                        end
                        else
                        begin
                            res.send_done = 1'b1;
                            ctl_next.mode = plbs_pkg::MODE_IDLE;
                        end
                    end
                end
                else if (ctl.mode == plbs_pkg::MODE_RECV)
                begin
                    if (ctl.bp == plbs_pkg::BP_W'(0))
                    begin
                        // start bit; hold phase so answer check follows at once
                        ctl_next.line  = 1'b1;
                        ctl_next.bp    = plbs_pkg::BP_W'(1);
                        ctl_next.phase = ctl.phase;
                        ctl_next.miss  = '0;
                    end
                    else if (ctl.bp == plbs_pkg::BP_W'(1))
                    begin
                        if (!line_sample)
                        begin
                            in_word_next = '0;
                            ctl_next.bp  = plbs_pkg::BP_W'(2);
                        end
                        else
                        begin
                            ctl_next.phase = ctl.phase;
                            ctl_next.miss  = miss_inc;
                            if (miss_over)
                            begin
                                ctl_next.line    = 1'b0;
                                res.recv_done    = 1'b1;
                                res.recv_timeout = 1'b1;
                                in_word_next     = '0;
                                ctl_next.mode    = plbs_pkg::MODE_IDLE;
                            end
                        end
                    end
                    else if (ctl.bp < LAST)
                    begin
                        in_word_next[idx] = in_word[idx] | line_sample;
                        ctl_next.bp       = ctl.bp + plbs_pkg::BP_W'(1);
                    end
                    else if (ctl.bp == LAST)
                    begin
                        ctl_next.line = 1'b0;
                        ctl_next.bp   = ctl.bp + plbs_pkg::BP_W'(1);
                    end
                    else
                    begin
                        res.recv_done     = 1'b1;
                        res.received_word = plbs_pkg::WORD_W'(in_word);
                        ctl_next.mode     = plbs_pkg::MODE_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.line_on  = ctl_next.line;
        res.busy_res = (ctl_next.mode != plbs_pkg::MODE_IDLE);
    end

endmodule

`default_nettype wire

// ===== rtl/power_line_bit_serial_master.sv =====
// Top level of the power line bit-serial master
//
//  Channel    Dir  Bits  Contents (low bit first)
//  s_axis     in   40    operation[1:0], send_word[33:2], line_sample[34]
//  m_axis     out  40    line_on, busy_res, send_done, recv_done, recv_timeout,
//                        received_word[36:5], rejected[37]
//  cfg        in   8     fault_limit, written when cfg_we is high
//
//  One item per cycle unless m_tready stalls; via input then result register.
//  The sequencer state updates as an item leaves the input register.
//  Reset puts the line off, idle, phase on the send side, fault_limit = 10.
//  A stalled result register backs up into the input register, then s_tready.
`timescale 1ns / 1ps
`default_nettype none

module power_line_bit_serial_master #(
    parameter int DATA_BITS = plbs_pkg::DATA_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // operation[1:0], send_word[33:2], line_sample[34], zero pad
    input  logic [plbs_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // line_on[0], busy_res[1], send_done[2], recv_done[3], recv_timeout[4],
    // received_word[36:5], rejected[37], zero pad
    output logic [plbs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [plbs_pkg::LIMIT_W-1:0]        cfg_wdata
);

    logic                              in_valid_reg;
    plbs_pkg::op_t                     in_op_reg;
    logic [plbs_pkg::WORD_W-1:0]       in_word_reg;
    logic                              in_sample_reg;

    plbs_pkg::ctl_t                    ctl_reg;
    plbs_pkg::ctl_t                    ctl_next;
    logic [DATA_BITS-1:0]              out_word_reg;
    logic [DATA_BITS-1:0]              out_word_next;
    logic                              out_word_load;
    logic [DATA_BITS-1:0]              rx_word_reg;
    logic [DATA_BITS-1:0]              rx_word_next;
    logic [plbs_pkg::LIMIT_W-1:0]      fault_limit_reg;

    logic                              out_valid_reg;
    plbs_pkg::res_t                    res_reg;
    plbs_pkg::res_t                    res_next;

    logic                              advance;
    logic                              s_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    plbs_step #(
        .DATA_BITS (DATA_BITS)
    ) u_step (
        .op            (in_op_reg),
        .send_word     (in_word_reg),
        .line_sample   (in_sample_reg),
        .fault_limit   (fault_limit_reg),
        .ctl           (ctl_reg),
        .out_word      (out_word_reg),
        .in_word       (rx_word_reg),
        .ctl_next      (ctl_next),
        .out_word_load (out_word_load),
        .out_word_next (out_word_next),
        .in_word_next  (rx_word_next),
        .res           (res_next)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            fault_limit_reg <= plbs_pkg::FAULT_LIMIT_RST;
            ctl_reg.phase   <= 1'b1;
            ctl_reg.bp      <= '0;
            ctl_reg.mode    <= plbs_pkg::MODE_IDLE;
            ctl_reg.miss    <= '0;
            ctl_reg.line    <= 1'b0;
            rx_word_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                fault_limit_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ctl_reg       <= ctl_next;
                rx_word_reg   <= rx_word_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_op_reg     <= plbs_pkg::op_t'(s_tdata[1:0]);
            in_word_reg   <= s_tdata[33:2];
            in_sample_reg <= s_tdata[34];
        end
        if (advance)
        begin
            res_reg <= res_next;
            if (out_word_load)
            begin
                out_word_reg <= out_word_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg};

endmodule

`default_nettype wire

// ===== rtl/plbs_checker.sv =====
// Port-level checker for the power line bit-serial master, with its bind
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module plbs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [plbs_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic busy;
    logic sdone;
    logic rdone;
    logic tout;
    logic rej;
    logic word_zero;

    assign busy      = m_tdata[1];
    assign sdone     = m_tdata[2];
    assign rdone     = m_tdata[3];
    assign tout      = m_tdata[4];
    assign rej       = m_tdata[37];
    assign word_zero = (m_tdata[36:5] == '0);

    `ASSERT_IMPL(a_one_done, clk, rst_n, m_tvalid, !(sdone && rdone))
    `ASSERT_IMPL(a_timeout_clean, clk, rst_n, m_tvalid && tout, rdone && word_zero)
    `ASSERT_IMPL(a_done_idle, clk, rst_n, m_tvalid && (sdone || rdone), !busy)
    `ASSERT_IMPL(a_reject_busy, clk, rst_n, m_tvalid && rej, busy && !sdone && !rdone)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind power_line_bit_serial_master plbs_checker u_plbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
